// ===== rtl/mp2x2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2x2_pkg: shared constants of the 2x2 max pool with argmax recall
// Field widths, register indexes and operation codes used by the core and
// by its port checker.
// ----------------------------------------------------------------------------
package mp2x2_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned PIDX_BITS  = 14;
  localparam int unsigned SIDE_BITS  = 7;
  localparam int unsigned CHAN_BITS  = 5;
  localparam int unsigned CFG_BITS   = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  // The argmax table is addressed by the pooled index itself.
  localparam int unsigned TABLE_DEPTH = 1 << PIDX_BITS;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [SIDE_BITS-1:0] SIDE_RESET     = 7'd64;
  localparam logic [CHAN_BITS-1:0] CHANNELS_RESET = 5'd1;

  // Operation codes carried in tuser (input) and direction codes (output).
  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;

endpackage

// ===== rtl/max_pool_2x2_argmax_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_argmax_core: 2x2 stride-2 max pooling with argmax recall
// Forward beats stream square planes in raster order; every closed window
// gives its maximum, the flat input index of the maximum and the pooled
// index. Backward beats route a blame value to the stored input index.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Contents
//  s_axis    in   tvalid/tready          tuser: operation; tdata: value, pooled_position
//  m_axis    out  tvalid/tready          tuser: direction; tdata: out_value,
//                                        input_position, pooled_index
//  cfg       in   cfg_we_i (no wait)     cfg_index_i selects side or channels
//
//  One beat per cycle is sustained in both directions while the output is not
//  stalled; a result is registered into the compare stage beside the registered
//  read of the row-pair buffer or the argmax table, then into the output register.
//  Reset clears the counters, the left sample and the valid flags and loads the
//  configuration reset values; both memories start undefined and need no clearing pass.
//  A stalled output holds the compare stage, and input is refused only when
//  both the compare stage and the output register are occupied.
// ----------------------------------------------------------------------------
module max_pool_2x2_argmax_core #(
  parameter int unsigned MAX_SIDE     = 64,
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned IN_W         = ((VALUE_BITS + 14 + 7) / 8) * 8,
  parameter int unsigned OUT_W        = ((VALUE_BITS + 30 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [mp2x2_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mp2x2_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // value, pooled_position
  input  logic                          s_axis_tuser,  // operation
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,  // out_value, input_position,
                                                       // pooled_index
  output logic                          m_axis_tuser   // direction
);

  import mp2x2_pkg::*;

  localparam int unsigned CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned XW    = (SW > SIDE_BITS) ? SW : SIDE_BITS;
  localparam int unsigned HALF  = MAX_SIDE / 2;
  localparam int unsigned RAW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CEW   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned YW    = (CEW > CHAN_BITS) ? CEW : CHAN_BITS;
  localparam int unsigned CAND  = VALUE_BITS + POS_BITS;
  localparam logic [XW-1:0] MAX_SIDE_X = XW'(MAX_SIDE);
  localparam logic [YW-1:0] MAX_CHAN_Y = YW'(MAX_CHANNELS);

  // Configuration and stream position.
  logic [SIDE_BITS-1:0] side_q;
  logic [CHAN_BITS-1:0] chan_q;
  logic [CW-1:0]        col_q, row_q;
  logic [CHW-1:0]       ch_q;
  logic [POS_BITS-1:0]  flat_q;
  logic [PIDX_BITS-1:0] pool_q;
  logic [CAND-1:0]      left_q;

  // Effective plane side and channel count.
  logic [XW-1:0] side_x, side_clip;
  logic [SW-1:0] eff_side;
  logic [YW-1:0] chan_y, chan_clip;
  logic [CEW-1:0] eff_chan;

  always_comb begin
    side_x    = XW'(side_q);
    side_clip = (side_x > MAX_SIDE_X) ? MAX_SIDE_X : side_x;
    side_clip[0] = 1'b0;
    if (side_clip < XW'(2)) begin
      side_clip = XW'(2);
    end
    eff_side  = SW'(side_clip);
    chan_y    = YW'(chan_q);
    chan_clip = (chan_y > MAX_CHAN_Y) ? MAX_CHAN_Y : chan_y;
    if (chan_clip == '0) begin
      chan_clip = YW'(1);
    end
    eff_chan  = CEW'(chan_clip);
  end

  // Input decode.
  logic                         accept, fwd_acc, back_acc;
  logic signed [VALUE_BITS-1:0] in_value;
  logic [PIDX_BITS-1:0]         in_ppos;
  logic                         col_last, row_last, ch_last, frame_end;
  logic                         col_odd, row_odd, emit;

  assign in_value  = $signed(s_axis_tdata[VALUE_BITS-1:0]);
  assign in_ppos   = s_axis_tdata[VALUE_BITS+PIDX_BITS-1:VALUE_BITS];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign fwd_acc   = accept && (s_axis_tuser == OP_FORWARD);
  assign back_acc  = accept && (s_axis_tuser == OP_BACKWARD);
  assign col_odd   = col_q[0];
  assign row_odd   = row_q[0];
  assign emit      = col_odd && row_odd;
  assign col_last  = (SW'(col_q) == eff_side - SW'(1));
  assign row_last  = (SW'(row_q) == eff_side - SW'(1));
  assign ch_last   = (CEW'(ch_q) == eff_chan - CEW'(1));
  assign frame_end = col_last && row_last && ch_last;

  // Upper row pair of each window: best of the two top samples.
  logic signed [VALUE_BITS-1:0] left_v;
  logic [CAND-1:0]              cur_cand, top_best, rp_rdata;
  logic [RAW-1:0]               slot;

  assign left_v   = $signed(left_q[CAND-1:POS_BITS]);
  assign cur_cand = {in_value, flat_q};
  assign top_best = (in_value > left_v) ? cur_cand : left_q;
  assign slot     = RAW'(col_q >> 1);

  mp2x2_ram #(
    .WIDTH (CAND),
    .DEPTH (HALF)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_acc && col_odd && !row_odd),
    .waddr_i (slot),
    .wdata_i (top_best),
    .re_i    (fwd_acc && emit),
    .raddr_i (slot),
    .rdata_o (rp_rdata)
  );

  // Compare stage.
  logic                 s1_valid_q, s1_back_q;
  logic [CAND-1:0]      s1_cur_q, s1_left_q;
  logic [PIDX_BITS-1:0] s1_pidx_q;
  logic                 byp_valid_q;
  logic [POS_BITS-1:0]  byp_pos_q;
  logic                 s1_adv;
  logic [CAND-1:0]      best_a, best_b;
  logic [POS_BITS-1:0]  tab_rdata, back_pos;
  logic                 tab_we;

  assign s1_adv = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !m_axis_tvalid || m_axis_tready;

  always_comb begin
    best_a = ($signed(s1_left_q[CAND-1:POS_BITS]) > $signed(rp_rdata[CAND-1:POS_BITS]))
             ? s1_left_q : rp_rdata;
    best_b = ($signed(s1_cur_q[CAND-1:POS_BITS]) > $signed(best_a[CAND-1:POS_BITS]))
             ? s1_cur_q : best_a;
  end

  assign tab_we   = s1_adv && !s1_back_q;
  assign back_pos = byp_valid_q ? byp_pos_q : tab_rdata;

  mp2x2_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_argmax_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (s1_pidx_q),
    .wdata_i (best_b[POS_BITS-1:0]),
    .re_i    (back_acc),
    .raddr_i (in_ppos),
    .rdata_o (tab_rdata)
  );

  // Output register.
  logic                         out_valid_q, out_dir_q;
  logic signed [VALUE_BITS-1:0] out_val_q;
  logic [POS_BITS-1:0]          out_ipos_q;
  logic [PIDX_BITS-1:0]         out_pidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SIDE_RESET;
      chan_q      <= CHANNELS_RESET;
      col_q       <= '0;
      row_q       <= '0;
      ch_q        <= '0;
      flat_q      <= '0;
      pool_q      <= '0;
      left_q      <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_SIDE || cfg_index_i == CFG_CHANNELS)) begin
        if (cfg_index_i == CFG_SIDE) begin
          side_q <= cfg_wdata_i[SIDE_BITS-1:0];
        end else begin
          chan_q <= cfg_wdata_i[CHAN_BITS-1:0];
        end
        col_q  <= '0;
        row_q  <= '0;
        ch_q   <= '0;
        flat_q <= '0;
        pool_q <= '0;
      end else if (fwd_acc) begin
        if (!col_odd) begin
          left_q <= cur_cand;
        end
        // The last sample of the last plane starts the next frame at zero.
        if (frame_end) begin
          pool_q <= '0;
          flat_q <= '0;
        end else begin
          if (emit) begin
            pool_q <= pool_q + PIDX_BITS'(1);
          end
          flat_q <= flat_q + POS_BITS'(1);
        end
        if (col_last) begin
          col_q <= '0;
          if (row_last) begin
            row_q <= '0;
            if (ch_last) begin
              ch_q <= '0;
            end else begin
              ch_q <= ch_q + CHW'(1);
            end
          end else begin
            row_q <= row_q + CW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      if (accept) begin
        s1_valid_q  <= back_acc || emit;
        // A table write at this edge is not seen by the read of the same entry.
        byp_valid_q <= back_acc && tab_we && (s1_pidx_q == in_ppos);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_back_q <= back_acc;
      s1_cur_q  <= cur_cand;
      s1_left_q <= left_q;
      s1_pidx_q <= back_acc ? in_ppos : pool_q;
      byp_pos_q <= best_b[POS_BITS-1:0];
    end
    if (s1_adv) begin
      out_dir_q  <= s1_back_q;
      out_pidx_q <= s1_pidx_q;
      if (s1_back_q) begin
        out_val_q  <= $signed(s1_cur_q[CAND-1:POS_BITS]);
        out_ipos_q <= back_pos;
      end else begin
        out_val_q  <= $signed(best_b[CAND-1:POS_BITS]);
        out_ipos_q <= best_b[POS_BITS-1:0];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_dir_q;
  assign m_axis_tdata  = OUT_W'({out_pidx_q, out_ipos_q, out_val_q});

endmodule

// ===== rtl/mp2x2_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2x2_ram: simple dual-port RAM with registered read
// One write port and one read port; a read returns the old contents when
// the same entry is written at the same edge.
// ----------------------------------------------------------------------------
module mp2x2_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mp2x2_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2x2_checker: port-level checks of the max pool core
// Watches the stream ports over time and is bound to every core instance.
// ----------------------------------------------------------------------------
module mp2x2_checker #(
  parameter int unsigned OUT_W = 48
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  import mp2x2_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // A result waiting at the output holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // With the output register empty the compare stage can always drain, and input is accepted.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused while output register empty");

  // A backward beat into an empty pipeline passes the compare stage and then appears at the output.
  a_back_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && s_axis_tuser == OP_BACKWARD && !m_axis_tvalid) ##1 !m_axis_tvalid |=>
      m_axis_tvalid && m_axis_tuser == OP_BACKWARD)
    else $error("backward beat did not reach the output");

endmodule

bind max_pool_2x2_argmax_core mp2x2_checker #(
  .OUT_W (OUT_W)
) u_mp2x2_checker (.*);
